// ===== design/stha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stha_pkg
// Types and constants shared by the slot table heap allocator modules.
// ----------------------------------------------------------------------------
package stha_pkg;

  localparam int unsigned REQ_W  = 19;
  localparam int unsigned ADDR_W = 19;
  localparam int unsigned SZ_W   = 20;
  localparam int unsigned SUM_W  = 22;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAKE,
    ST_PRIME,
    ST_RELEASE
  } state_t;

  typedef struct packed {
    logic            used;
    logic [SZ_W-1:0] addr;
    logic [SZ_W-1:0] size;
  } slot_t;

  typedef struct packed {
    logic             hit;
    logic             overflow;
    logic [SUM_W-1:0] base_nxt;
  } eval_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

// ===== design/stha_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stha_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module stha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/stha_slot_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stha_slot_eval
// Shared slot unit: heap bound check, fit or address match, running base.
// ----------------------------------------------------------------------------
module stha_slot_eval (
  input  logic                        take_mode,
  input  logic [stha_pkg::SZ_W-1:0]   req_size,
  input  logic [stha_pkg::ADDR_W-1:0] block_address,
  input  logic [stha_pkg::SUM_W-1:0]  base,
  input  logic [stha_pkg::SUM_W-1:0]  heap_limit,
  input  stha_pkg::slot_t             slot,
  output stha_pkg::eval_t             result
);
  import stha_pkg::*;

  logic [SUM_W-1:0] end_addr;
  logic             fits;
  logic             matches_addr;

  always_comb begin
    end_addr     = base + SUM_W'(req_size);
    fits         = !slot.used && ((slot.size == '0) || (slot.size > req_size));
    matches_addr = slot.used && (slot.addr == {1'b0, block_address});
    result.overflow = take_mode && (end_addr > heap_limit);
    result.hit      = take_mode ? fits : matches_addr;
    result.base_nxt = base + SUM_W'(slot.size);
  end

endmodule

// ===== design/slot_table_heap_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_heap_allocator_top
// Heap allocator over a row of slots held in one RAM and walked one slot a
// cycle by a shared evaluation unit under a small sequencer.
// ----------------------------------------------------------------------------
// Channel   Ports                                          Handshake
// request   in_operation, in_request_size, in_block_address start & !busy
// result    out_new_address, out_granted, out_old_found,   out_strobe, one cycle
//           out_copy_length
//
// After reset the slot RAM is cleared slot by slot with busy high. Allocate
// and free walk the slots at most once and reallocate at most twice, paced by
// the single RAM read port that the walk steps through one slot a cycle. An
// unused operation code answers in the next cycle. Results cannot be held off
// by the receiver.
// ----------------------------------------------------------------------------
module slot_table_heap_allocator_top #(
  parameter int unsigned SLOT_COUNT = 128,
  parameter int unsigned HEAP_BYTES = 393216
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [stha_pkg::REQ_W-1:0]  in_request_size,
  input  logic [stha_pkg::ADDR_W-1:0] in_block_address,
  output logic                        out_strobe,
  output logic [stha_pkg::ADDR_W-1:0] out_new_address,
  output logic                        out_granted,
  output logic                        out_old_found,
  output logic [stha_pkg::ADDR_W-1:0] out_copy_length
);
  import stha_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [SUM_W-1:0] HEAP_LIMIT = SUM_W'(HEAP_BYTES);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [SZ_W-1:0]    size_r, size_nxt;
  logic [ADDR_W-1:0]  blk_r, blk_nxt;
  logic [SUM_W-1:0]   base_r, base_nxt;
  logic [ADDR_W-1:0]  grant_r, grant_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic               out_granted_r, out_granted_nxt;
  logic               out_old_r, out_old_nxt;
  logic [ADDR_W-1:0]  out_copy_r, out_copy_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  slot_t              ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [SLOT_W-1:0]  ram_rdata;
  slot_t              slot;
  eval_t              ev;
  logic [SZ_W-1:0]    rounded;
  logic               is_last;

  assign slot    = slot_t'(ram_rdata);
  assign rounded = ({1'b0, in_request_size} + SZ_W'(3)) & ~SZ_W'(3);
  assign is_last = (idx_r == LAST_IDX);

  stha_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stha_slot_eval u_slot_eval (
    .take_mode     (state_r == ST_TAKE),
    .req_size      (size_r),
    .block_address (blk_r),
    .base          (base_r),
    .heap_limit    (HEAP_LIMIT),
    .slot          (slot),
    .result        (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    size_r        <= size_nxt;
    blk_r         <= blk_nxt;
    base_r        <= base_nxt;
    grant_r       <= grant_nxt;
    out_addr_r    <= out_addr_nxt;
    out_granted_r <= out_granted_nxt;
    out_old_r     <= out_old_nxt;
    out_copy_r    <= out_copy_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (in_operation)
            OP_ALLOC, OP_REALLOC: state_nxt = ST_TAKE;
            OP_FREE:              state_nxt = ST_RELEASE;
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TAKE: begin
        if (ev.overflow) begin
          state_nxt = ST_IDLE;
        end else if (ev.hit) begin
          state_nxt = (op_r == OP_REALLOC) ? ST_PRIME : ST_IDLE;
        end else if (is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PRIME: state_nxt = ST_RELEASE;
      ST_RELEASE: begin
        if (ev.hit || is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt         = idx_r;
    op_nxt          = op_r;
    size_nxt        = size_r;
    blk_nxt         = blk_r;
    base_nxt        = base_r;
    grant_nxt       = grant_r;
    out_strobe_nxt  = 1'b0;
    out_addr_nxt    = out_addr_r;
    out_granted_nxt = out_granted_r;
    out_old_nxt     = out_old_r;
    out_copy_nxt    = out_copy_r;
    ram_we          = 1'b0;
    ram_waddr       = idx_r;
    ram_wdata       = slot;
    ram_raddr       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        idx_nxt   = is_last ? '0 : idx_r + IDX_W'(1);
      end
      ST_IDLE: begin
        if (start) begin
          op_nxt   = in_operation;
          size_nxt = rounded;
          blk_nxt  = in_block_address;
          base_nxt = '0;
          idx_nxt  = '0;
          if (in_operation != OP_ALLOC && in_operation != OP_FREE &&
              in_operation != OP_REALLOC) begin
            out_strobe_nxt  = 1'b1;
            out_addr_nxt    = '0;
            out_granted_nxt = 1'b0;
            out_old_nxt     = 1'b0;
            out_copy_nxt    = '0;
          end
        end
      end
      ST_TAKE: begin
        ram_raddr = idx_r + IDX_W'(1);
        if (ev.overflow || (!ev.hit && is_last)) begin
          out_strobe_nxt  = 1'b1;
          out_addr_nxt    = '0;
          out_granted_nxt = 1'b0;
          out_old_nxt     = 1'b0;
          out_copy_nxt    = '0;
        end else if (ev.hit) begin
          ram_we         = 1'b1;
          ram_wdata.used = 1'b1;
          ram_wdata.addr = base_r[SZ_W-1:0];
          ram_wdata.size = (slot.size == '0) ? size_r : slot.size;
          grant_nxt      = base_r[ADDR_W-1:0];
          if (op_r == OP_ALLOC) begin
            out_strobe_nxt  = 1'b1;
            out_addr_nxt    = base_r[ADDR_W-1:0];
            out_granted_nxt = 1'b1;
            out_old_nxt     = 1'b0;
            out_copy_nxt    = '0;
          end
        end else begin
          idx_nxt  = idx_r + IDX_W'(1);
          base_nxt = ev.base_nxt;
        end
      end
      ST_PRIME: begin
        idx_nxt = '0;
      end
      ST_RELEASE: begin
        ram_raddr = idx_r + IDX_W'(1);
        if (ev.hit) begin
          ram_we          = 1'b1;
          ram_wdata.used  = 1'b0;
          out_strobe_nxt  = 1'b1;
          out_granted_nxt = 1'b1;
          if (op_r == OP_REALLOC) begin
            out_addr_nxt = grant_r;
            out_old_nxt  = 1'b1;
            out_copy_nxt = slot.size[ADDR_W-1:0];
          end else begin
            out_addr_nxt = '0;
            out_old_nxt  = 1'b0;
            out_copy_nxt = '0;
          end
        end else if (is_last) begin
          out_strobe_nxt = 1'b1;
          out_old_nxt    = 1'b0;
          out_copy_nxt   = '0;
          if (op_r == OP_REALLOC) begin
            out_addr_nxt    = grant_r;
            out_granted_nxt = 1'b1;
          end else begin
            out_addr_nxt    = '0;
            out_granted_nxt = 1'b0;
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_new_address = out_addr_r;
  assign out_granted     = out_granted_r;
  assign out_old_found   = out_old_r;
  assign out_copy_length = out_copy_r;

endmodule
